@@ design/pvm_pkg.sv @@
// Package with the shared types and constants of the PCM voice mixer.
package pvm_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_MUSIC = 2'd1,
      OP_SOUND = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   // One voice record as held in the voice memory.
   typedef struct packed {
      logic [15:0] base;
      logic [15:0] length;
      logic [15:0] position;
      logic [15:0] lbegin;
      logic [15:0] lfinish;
      logic        loop_on;
   } voice_type;

   localparam logic signed [23:0] SAT_MAX = 24'sd32767;
   localparam logic signed [23:0] SAT_MIN = -24'sd32768;

endpackage

@@ design/pcm_voice_mixer_top.sv @@
// Top level of the PCM voice mixer: sample memory, voice memory and tick sequencer.
// Writes and plays end with the start state; a tick runs start, then voice read,
// sample read and write-back per voice, then done. Each voice costs a voice-memory
// read, a sample-memory read and, if active, a voice write-back, done strictly in
// turn by the tick sequencer. The result waits in an output register, and the next
// request is taken while it is still stalled, provided the sequencer is idle. No
// clearing pass: a voice record is only used once its active bit says it was written.
module pcm_voice_mixer_top #(
   parameter int CHANNELS         = 8,
   parameter int SAMPLE_MEM_DEPTH = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op_code,
   input  logic [15:0]        req_mem_address,
   input  logic [7:0]         req_data_byte,
   input  logic [15:0]        req_sample_length,
   input  logic [15:0]        req_loop_begin,
   input  logic [15:0]        req_loop_finish,
   input  logic               req_loop_enable,
   input  logic               req_save_current,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_mixed_sample,
   output logic               rsp_clipped,
   output logic [7:0]         rsp_busy_channels
);

   localparam int VW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW = $clog2(SAMPLE_MEM_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_START = 6'b000010,
      ST_VREAD = 6'b000100,
      ST_SREAD = 6'b001000,
      ST_WBACK = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]                 smem [SAMPLE_MEM_DEPTH];
   pvm_pkg::voice_type         vmem [CHANNELS];
   logic [CHANNELS-1:0]        active_ff, active_in;
   pvm_pkg::voice_type         saved_ff, saved_in;
   logic                       resume_ff, resume_in;
   logic [VW-1:0]              vidx_ff, vidx_in;
   pvm_pkg::voice_type         cur_ff, cur_in;
   pvm_pkg::voice_type         vrd_ff;
   logic [7:0]                 srd_ff;
   logic                       play_ff, play_in;
   logic signed [23:0]         sum_ff, sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]         mix_ff, mix_in;
   logic                       clip_ff, clip_in;
   logic [7:0]                 busy_ff, busy_in;

   // Latched request.
   pvm_pkg::op_type            op_ff;
   logic [15:0]                addr_ff, len_ff, lb_ff, lf_ff;
   logic [7:0]                 data_ff;
   logic                       le_ff, sc_ff;

   logic                       accept;
   logic                       vwe;
   logic [VW-1:0]              vwaddr;
   pvm_pkg::voice_type         vwdata, newv, stepv;
   logic [VW-1:0]              pick;
   logic [15:0]                saddr;
   logic                       last_voice;
   logic [16:0]                pos_inc;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign last_voice = (32'(vidx_ff) == CHANNELS - 1);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= pvm_pkg::op_type'(req_op_code);
         addr_ff <= req_mem_address;
         data_ff <= req_data_byte;
         len_ff  <= req_sample_length;
         lb_ff   <= req_loop_begin;
         lf_ff   <= req_loop_finish;
         le_ff   <= req_loop_enable;
         sc_ff   <= req_save_current;
      end
   end

   // Lowest free voice from 1 up, else voice 1.
   always_comb begin
      pick = VW'(1);
      for (int v = CHANNELS - 1; v >= 1; v--) begin
         if (!active_ff[v]) begin
            pick = VW'(v);
         end
      end
   end

   always_comb begin
      newv.base     = addr_ff;
      newv.length   = len_ff;
      newv.position = 16'd0;
      newv.lbegin   = lb_ff;
      newv.lfinish  = lf_ff;
      newv.loop_on  = le_ff;
   end

   // Step of the current voice once its sample byte is in.
   always_comb begin
      stepv   = cur_ff;
      pos_inc = {1'b0, cur_ff.position} + 17'd1;
      if (play_ff) begin
         stepv.position = pos_inc[15:0];
         if (cur_ff.loop_on && pos_inc[15:0] >= cur_ff.lfinish) begin
            stepv.position = cur_ff.lbegin;
         end
      end
   end

   assign saddr = cur_ff.base + cur_ff.position;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      saved_in     = saved_ff;
      resume_in    = resume_ff;
      vidx_in      = vidx_ff;
      cur_in       = cur_ff;
      play_in      = play_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mix_in       = mix_ff;
      clip_in      = clip_ff;
      busy_in      = busy_ff;
      vwe          = 1'b0;
      vwaddr       = vidx_ff;
      vwdata       = stepv;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_IDLE;
            case (op_ff)
               pvm_pkg::OP_MUSIC: begin
                  vwe    = 1'b1;
                  vwaddr = '0;
                  vwdata = newv;
                  active_in[0] = 1'b1;
                  if (sc_ff && active_ff[0]) begin
                     saved_in  = vrd_ff;
                     resume_in = 1'b1;
                  end else begin
                     saved_in  = '0;
                     resume_in = 1'b0;
                  end
               end
               pvm_pkg::OP_SOUND: begin
                  vwe    = 1'b1;
                  vwaddr = pick;
                  vwdata = newv;
                  active_in[pick] = 1'b1;
               end
               pvm_pkg::OP_TICK: begin
                  vidx_in  = '0;
                  sum_in   = '0;
                  state_in = ST_VREAD;
               end
               default: ;
            endcase
         end
         ST_VREAD: begin
            // Voice record read issued last cycle; decide resume and play.
            cur_in  = vrd_ff;
            play_in = 1'b0;
            if (active_ff[vidx_ff]) begin
               if (vrd_ff.position < vrd_ff.length) begin
                  play_in = 1'b1;
               end else if (vidx_ff == '0 && resume_ff) begin
                  cur_in    = saved_ff;
                  resume_in = 1'b0;
                  play_in   = saved_ff.position < saved_ff.length;
               end
            end
            state_in = ST_SREAD;
         end
         ST_SREAD: begin
            state_in = ST_WBACK;
         end
         ST_WBACK: begin
            if (play_ff) begin
               sum_in = sum_ff + 24'(signed'({srd_ff, 8'd0}));
            end
            if (active_ff[vidx_ff]) begin
               vwe = 1'b1;
               if (stepv.position >= stepv.length && !(vidx_ff == '0 && resume_ff)) begin
                  active_in[vidx_ff] = 1'b0;
               end
            end
            if (last_voice) begin
               state_in = ST_DONE;
            end else begin
               vidx_in  = vidx_ff + VW'(1);
               state_in = ST_VREAD;
            end
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               clip_in      = 1'b0;
               mix_in       = sum_ff[15:0];
               if (sum_ff > pvm_pkg::SAT_MAX) begin
                  mix_in  = 16'sh7fff;
                  clip_in = 1'b1;
               end else if (sum_ff < pvm_pkg::SAT_MIN) begin
                  mix_in  = -16'sh8000;
                  clip_in = 1'b1;
               end
               for (int v = 0; v < 8; v++) begin
                  busy_in[v] = (v < CHANNELS) ? active_ff[v % CHANNELS] : 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         saved_ff     <= '0;
         resume_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         saved_ff     <= saved_in;
         resume_ff    <= resume_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vidx_ff <= vidx_in;
      cur_ff  <= cur_in;
      play_ff <= play_in;
      sum_ff  <= sum_in;
      mix_ff  <= mix_in;
      clip_ff <= clip_in;
      busy_ff <= busy_in;
   end

   // Voice memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[vwaddr] <= vwdata;
      end
      if (state_ff == ST_IDLE || state_ff == ST_WBACK) begin
         vrd_ff <= vmem[(state_ff == ST_IDLE) ? VW'(0) : vidx_in];
      end else if (state_ff == ST_START) begin
         vrd_ff <= vmem[VW'(0)];
      end
   end

   // Sample memory: byte writes from requests, reads during a tick.
   always_ff @(posedge clock) begin
      if (state_ff == ST_START && op_ff == pvm_pkg::OP_WRITE) begin
         smem[addr_ff[AW-1:0]] <= data_ff;
      end
      if (state_ff == ST_SREAD) begin
         srd_ff <= smem[saddr[AW-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mixed_sample  = mix_ff;
   assign rsp_clipped       = clip_ff;
   assign rsp_busy_channels = busy_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mixed_sample)))
      else $error("stalled result changed");
   a_clip_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_mixed_sample == 16'sh7fff || rsp_mixed_sample == -16'sh8000))
      else $error("clip flag without saturated value");
   a_tick_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WBACK && last_voice) |=> (state_ff == ST_DONE))
      else $error("tick sequencer lost its place");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the PCM voice mixer: directed and random requests.
`timescale 1ns / 100ps

module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op_code = pvm_pkg::OP_TICK;
   logic [15:0]        req_mem_address = '0;
   logic [7:0]         req_data_byte = '0;
   logic [15:0]        req_sample_length = '0;
   logic [15:0]        req_loop_begin = '0;
   logic [15:0]        req_loop_finish = '0;
   logic               req_loop_enable = 1'b0;
   logic               req_save_current = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_mixed_sample;
   logic               rsp_clipped;
   logic [7:0]         rsp_busy_channels;

   typedef struct {
      logic signed [15:0] mix;
      logic               clip;
      logic [7:0]         busy;
   } mix_result;

   // Local copy of the mixer state.
   logic [7:0]          mem_img [0:65535];
   bit                  mem_known [0:65535];
   pvm_pkg::voice_type  voices [0:7];
   bit                  active [0:7];
   pvm_pkg::voice_type  saved;
   bit                  resume_pending;

   mix_result   expected_mix [$];
   int          fail_count = 0;
   bit          hold_rsp = 1'b0;
   int          hold_cycles = 0;
   int          rsp_wait = 0;

   pcm_voice_mixer_top i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int signed voice_advance(int v);
      int signed s;
      logic [15:0] a;
      if (voices[v].position >= voices[v].length) return 0;
      a = voices[v].base + voices[v].position;
      s = $signed(mem_img[a]) * 256;
      voices[v].position = voices[v].position + 16'd1;
      if (voices[v].loop_on && voices[v].position >= voices[v].lfinish)
         voices[v].position = voices[v].lbegin;
      return s;
   endfunction

   function automatic void start_voice(int v, logic [15:0] b, logic [15:0] len,
                                       logic [15:0] lb, logic [15:0] lf, logic le);
      voices[v] = '{base: b, length: len, position: 16'd0, lbegin: lb,
                    lfinish: lf, loop_on: le};
      active[v] = 1'b1;
   endfunction

   // Applies one accepted request to the local state.
   function automatic void mixer_apply(pvm_pkg::op_type op, logic [15:0] addr,
                                       logic [7:0] data, logic [15:0] len,
                                       logic [15:0] lb, logic [15:0] lf, logic le,
                                       logic sv);
      int signed sum;
      int pick;
      mix_result r;
      case (op)
         pvm_pkg::OP_WRITE: begin
            mem_img[addr] = data;
            mem_known[addr] = 1'b1;
         end
         pvm_pkg::OP_MUSIC: begin
            if (sv && active[0]) begin
               saved = voices[0];
               resume_pending = 1'b1;
            end else begin
               saved = '0;
               resume_pending = 1'b0;
            end
            start_voice(0, addr, len, lb, lf, le);
         end
         pvm_pkg::OP_SOUND: begin
            pick = 1;
            for (int v = 7; v >= 1; v--) if (!active[v]) pick = v;
            start_voice(pick, addr, len, lb, lf, le);
         end
         default: begin
            sum = 0;
            r.busy = '0;
            for (int v = 0; v < 8; v++) begin
               if (active[v]) begin
                  if (voices[v].position < voices[v].length) sum += voice_advance(v);
                  else if (v == 0 && resume_pending) begin
                     voices[0] = saved;
                     resume_pending = 1'b0;
                     sum += voice_advance(0);
                  end
                  if (voices[v].position >= voices[v].length && !(v == 0 && resume_pending))
                     active[v] = 1'b0;
               end
               r.busy[v] = active[v];
            end
            r.clip = 1'b0;
            if (sum > 32767) begin
               sum = 32767;
               r.clip = 1'b1;
            end
            if (sum < -32768) begin
               sum = -32768;
               r.clip = 1'b1;
            end
            r.mix = sum[15:0];
            expected_mix.push_back(r);
         end
      endcase
   endfunction

   // True if every byte a tick would read is already written.
   function automatic bit tick_safe();
      logic [15:0] a;
      pvm_pkg::voice_type t;
      for (int v = 0; v < 8; v++) begin
         if (active[v]) begin
            t = voices[v];
            if (t.position >= t.length && v == 0 && resume_pending) t = saved;
            if (t.position < t.length) begin
               a = t.base + t.position;
               if (!mem_known[a]) return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   task automatic send_request(pvm_pkg::op_type op, logic [15:0] addr = '0,
                               logic [7:0] data = '0, logic [15:0] len = '0,
                               logic [15:0] lb = '0, logic [15:0] lf = '0,
                               logic le = 1'b0, logic sv = 1'b0, bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7));
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // A tick that would read unwritten memory becomes a write of that byte.
      if (op == pvm_pkg::OP_TICK && !tick_safe()) begin
         for (int v = 0; v < 8; v++)
            if (active[v] && voices[v].position < voices[v].length &&
                !mem_known[voices[v].base + voices[v].position]) begin
               op = pvm_pkg::OP_WRITE;
               addr = voices[v].base + voices[v].position;
               data = 8'($urandom);
            end
         if (op == pvm_pkg::OP_TICK) begin
            op = pvm_pkg::OP_WRITE;
            addr = saved.base + saved.position;
            data = 8'($urandom);
         end
      end
      req_valid <= 1'b1;
      req_op_code <= op;
      req_mem_address <= addr;
      req_data_byte <= data;
      req_sample_length <= len;
      req_loop_begin <= lb;
      req_loop_finish <= lf;
      req_loop_enable <= le;
      req_save_current <= sv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mixer_apply(op, addr, data, len, lb, lf, le, sv);
   endtask

   // Stops offering requests and waits until every expected result has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_mix.size() != 0) @(posedge clock);
   endtask

   // Fills a region with random bytes so plays from it are safe.
   task automatic fill_region(logic [15:0] base, int count, bit no_gap = 1'b0);
      for (int i = 0; i < count; i++)
         send_request(pvm_pkg::OP_WRITE, base + i[15:0], 8'($urandom), .no_gap(no_gap));
   endtask

   task automatic test_directed();
      send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_WRITE, 16'hFFFF, 8'h7F);
      send_request(pvm_pkg::OP_WRITE, 16'h0000, 8'h80);
      send_request(pvm_pkg::OP_WRITE, 16'h0001, 8'hFF);
      // Address wrap from the top of memory into the bottom.
      send_request(pvm_pkg::OP_MUSIC, 16'hFFFF, 8'h00, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0);
      for (int i = 0; i < 7; i++) send_request(pvm_pkg::OP_SOUND, 16'hFFFF, 8'd0, 16'd1);
      send_request(pvm_pkg::OP_SOUND, 16'h0000, 8'd0, 16'd2);
      send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_SOUND, 16'h0000, 8'd0, 16'd0);
      send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_TICK);
      wait_drained();
   endtask

   task automatic test_clipping();
      send_request(pvm_pkg::OP_WRITE, 16'h0010, 8'h7F);
      send_request(pvm_pkg::OP_WRITE, 16'h0011, 8'h80);
      for (int k = 0; k < 2; k++) begin
         send_request(pvm_pkg::OP_MUSIC, 16'(16'h0010 + k), 8'd0, 16'd1);
         for (int i = 0; i < 7; i++)
            send_request(pvm_pkg::OP_SOUND, 16'(16'h0010 + k), 8'd0, 16'd1);
         send_request(pvm_pkg::OP_TICK);
      end
      wait_drained();
   endtask

   task automatic test_save_resume();
      fill_region(16'h0100, 8);
      send_request(pvm_pkg::OP_MUSIC, 16'h0100, 8'd0, 16'd8, 16'd2, 16'd6, 1'b1, 1'b0);
      send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_MUSIC, 16'h0104, 8'd0, 16'd2, 16'd0, 16'd0, 1'b0, 1'b1);
      repeat (6) send_request(pvm_pkg::OP_TICK);
      // Zero-length jingle with a pending resume.
      send_request(pvm_pkg::OP_MUSIC, 16'h0100, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
      repeat (3) send_request(pvm_pkg::OP_TICK);
      send_request(pvm_pkg::OP_MUSIC, 16'h0100, 8'd0, 16'd2, 16'd0, 16'd0, 1'b0, 1'b1);
      repeat (4) send_request(pvm_pkg::OP_TICK);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++) send_request(pvm_pkg::OP_TICK, .no_gap(1'b1));
      wait_drained();
   endtask

   task automatic test_random();
      int r;
      logic [15:0] base, len;
      for (int n = 0; n < 470; n++) begin
         r = $urandom_range(0, 99);
         base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15) * 64);
         len = 16'($urandom_range(0, 12));
         if ($urandom_range(0, 30) == 0) len = 16'($urandom);
         if (r < 10) send_request(pvm_pkg::OP_WRITE, 16'($urandom), 8'($urandom));
         else if (r < 18) begin
            if (len > 64) len = 16'($urandom_range(0, 12));
            fill_region(base, len);
            send_request(pvm_pkg::OP_MUSIC, base, 8'd0, len, 16'($urandom_range(0, 12)),
                         ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 14)), 1'($urandom), 1'($urandom));
         end else if (r < 28) begin
            if (len > 64) len = 16'($urandom_range(0, 12));
            fill_region(base, len);
            send_request(pvm_pkg::OP_SOUND, base, 8'd0, len, 16'($urandom),
                         16'($urandom_range(0, 14)), 1'($urandom), 1'($urandom));
         end else send_request(pvm_pkg::OP_TICK);
         if (n == 235) wait_drained();
      end
      wait_drained();
   endtask

   // Response stall: a random wait drawn per result, or a long counted hold-off.
   always @(posedge clock) begin
      int wait_draw;
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
         if (hold_cycles == 0) hold_rsp <= 1'b0;
         else hold_cycles <= hold_cycles - 1;
      end else if (rsp_valid && !rsp_stall) begin
         wait_draw = $urandom_range(0, 7);
         rsp_stall <= (wait_draw != 0);
         rsp_wait <= wait_draw;
      end else if (rsp_stall) begin
         if (rsp_wait <= 1) rsp_stall <= 1'b0;
         rsp_wait <= rsp_wait - 1;
      end
   end

   always @(posedge clock) begin
      mix_result e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_mix.size() == 0) begin
            $display("%0t: unexpected result mix=%0d", $time, rsp_mixed_sample);
            fail_count++;
         end else begin
            e = expected_mix.pop_front();
            if (rsp_mixed_sample !== e.mix) begin
               $display("%0t: mixed_sample expected %0d actual %0d", $time, e.mix,
                        rsp_mixed_sample);
               fail_count++;
            end
            if (rsp_clipped !== e.clip) begin
               $display("%0t: clipped expected %0b actual %0b", $time, e.clip, rsp_clipped);
               fail_count++;
            end
            if (rsp_busy_channels !== e.busy) begin
               $display("%0t: busy_channels expected %h actual %h", $time, e.busy,
                        rsp_busy_channels);
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 65536; i++) begin
         mem_img[i] = '0;
         mem_known[i] = 1'b0;
      end
      for (int v = 0; v < 8; v++) begin
         voices[v] = '0;
         active[v] = 1'b0;
      end
      saved = '0;
      resume_pending = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_clipping();
      test_save_resume();
      test_backpressure();
      test_random();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_mix.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ pcm_voice_mixer_top.f @@
design/pvm_pkg.sv
design/pcm_voice_mixer_top.sv
tb/tb.sv
